// File: src/fsm_pkg.sv
package fsm_pkg;

   localparam int StackDepth = 128;
   localparam int AddrWidth = $clog2(StackDepth);
   localparam int CountWidth = $clog2(StackDepth + 1);

   localparam logic [4:0] OP_PUSH = 5'd0;
   localparam logic [4:0] OP_ADD = 5'd1;
   localparam logic [4:0] OP_SUB = 5'd2;
   localparam logic [4:0] OP_MUL = 5'd3;
   localparam logic [4:0] OP_DIV = 5'd4;
   localparam logic [4:0] OP_SWAP = 5'd5;
   localparam logic [4:0] OP_DUP = 5'd6;
   localparam logic [4:0] OP_DROP = 5'd7;
   localparam logic [4:0] OP_OVER = 5'd8;
   localparam logic [4:0] OP_ROT = 5'd9;
   localparam logic [4:0] OP_AND = 5'd10;
   localparam logic [4:0] OP_OR = 5'd11;
   localparam logic [4:0] OP_XOR = 5'd12;
   localparam logic [4:0] OP_NOT = 5'd13;
   localparam logic [4:0] OP_EQ = 5'd14;
   localparam logic [4:0] OP_LT = 5'd15;
   localparam logic [4:0] OP_GT = 5'd16;
   localparam logic [4:0] OP_DOT = 5'd17;
   localparam logic [4:0] OP_NOTEON = 5'd18;
   localparam logic [4:0] OP_NOTEOFF = 5'd19;
   localparam logic [4:0] OP_CC = 5'd20;
   localparam logic [4:0] OP_PANIC = 5'd21;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_PRINT = 2'd1;
   localparam logic [1:0] KIND_MIDI = 2'd2;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
   localparam logic [2:0] ERR_PORT = 3'd2;
   localparam logic [2:0] ERR_CHANNEL = 3'd3;
   localparam logic [2:0] ERR_PITCH = 3'd4;
   localparam logic [2:0] ERR_VELOCITY = 3'd5;

   localparam logic [7:0] MSG_NOTE_ON = 8'h90;
   localparam logic [7:0] MSG_NOTE_OFF = 8'h80;
   localparam logic [7:0] MSG_CTRL = 8'hB0;
   localparam logic [6:0] CTRL_ALL_OFF = 7'd123;

   typedef enum logic [2:0] {
      ALU_A = 3'd0, ALU_ADD = 3'd1, ALU_SUB = 3'd2, ALU_AND = 3'd3,
      ALU_OR = 3'd4, ALU_XOR = 3'd5, ALU_NOT = 3'd6, ALU_CMP = 3'd7
   } alu_op_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic        pop;
      logic        peek;
      logic        push;
      logic [2:0]  push_sel;
      logic [1:0]  load_sel;
      logic        load;
      logic        clear_flags;
      logic        div_start;
      logic        mul_start;
   } dp_cmd_type;

   typedef struct packed {
      logic        read_valid;
      logic        div_busy;
      logic        mul_busy;
      logic        div_zero;
   } dp_status_type;

   localparam logic [2:0] PUSH_LIT = 3'd0;
   localparam logic [2:0] PUSH_ALU = 3'd1;
   localparam logic [2:0] PUSH_REG_A = 3'd2;
   localparam logic [2:0] PUSH_REG_B = 3'd3;
   localparam logic [2:0] PUSH_REG_C = 3'd4;

   localparam logic [1:0] LOAD_A = 2'd0;
   localparam logic [1:0] LOAD_B = 2'd1;
   localparam logic [1:0] LOAD_C = 2'd2;

endpackage

// File: src/forth_stack_machine_midi_out.sv
// Forth-style data stack engine with MIDI message output.
// An item on the req_ channel carries an operation and a literal. Each
// item produces one to sixteen result items on the rsp_ channel, the
// final one marked by rsp_last. Panic with port_open set produces
// sixteen All-Notes-Off messages; anything else produces exactly one result.
// csr_ writes the port_open register; write it only while idle.
// Timing follows the stack memory's registered read port: each pop or
// peek is issued in ST_POP and its data is loaded in ST_WAIT. An item
// is accepted in ST_IDLE, pops its operands, then passes ST_EXEC, ST_PUSH
// where it pushes, and ST_EMIT; ST_PUSH waits on the registered multiplier
// and on the divider, which produces one quotient bit per cycle.
// The block takes one item at a time.
// Results sit in an output register; while the receiver holds rsp_ready
// low the block waits with the result held. Reset empties the stack and
// clears port_open; the stack contents need no clearing.
module forth_stack_machine_midi_out
   import fsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_operation,
   input  logic [31:0] req_literal,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_printed_value,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_data_one,
   output logic [6:0]  rsp_data_two,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_underflow,
   output logic        rsp_overflow,
   output logic [7:0]  rsp_stack_depth,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_port_open
);
   dp_cmd_type cmd;
   dp_status_type status;
   alu_op_type alu_op;
   logic cmp_eq, cmp_swap;
   logic [31:0] reg_a, reg_b, reg_c, alu_out, lit_ff;
   logic under, over;
   logic [7:0] depth;
   logic emit, emit_ready, emit_last;
   logic [1:0] emit_kind;
   logic [7:0] emit_status;
   logic [6:0] emit_d1, emit_d2;
   logic [2:0] emit_err;
   logic port_ff, vld_ff;

   assign csr_ready = 1'b1;
   assign emit_ready = !vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         if (csr_valid) port_ff <= csr_port_open;
         if (emit && emit_ready) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
      if (req_valid && req_ready) lit_ff <= req_literal;
      if (emit && emit_ready) begin
         rsp_kind <= emit_kind;
         rsp_printed_value <= (emit_kind == KIND_PRINT) ? reg_a : 32'd0;
         rsp_status_byte <= emit_status;
         rsp_data_one <= emit_d1;
         rsp_data_two <= emit_d2;
         rsp_error_code <= emit_err;
         rsp_underflow <= under;
         rsp_overflow <= over;
         rsp_stack_depth <= depth;
         rsp_last <= emit_last;
      end
   end
   assign rsp_valid = vld_ff;

   fsm_control u_control (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .req_operation (req_operation), .port_open (port_ff),
      .status (status), .cmd (cmd), .alu_op (alu_op),
      .cmp_eq (cmp_eq), .cmp_swap (cmp_swap),
      .reg_a (reg_a), .reg_b (reg_b), .reg_c (reg_c),
      .emit (emit), .emit_ready (emit_ready), .emit_kind (emit_kind),
      .emit_status (emit_status), .emit_d1 (emit_d1), .emit_d2 (emit_d2),
      .emit_err (emit_err), .emit_last (emit_last)
   );

   fsm_datapath u_datapath (
      .clock (clock), .reset (reset), .cmd (cmd), .alu_op (alu_op),
      .cmp_eq (cmp_eq), .cmp_swap (cmp_swap), .literal (lit_ff),
      .status (status), .reg_a (reg_a), .reg_b (reg_b), .reg_c (reg_c),
      .alu_out (alu_out), .underflow (under), .overflow (over),
      .depth (depth)
   );
endmodule

// File: src/fsm_div.sv
module fsm_div
   import fsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[31] ? 32'd0 - dividend : dividend;
         den_in = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in = dividend[31] ^ divisor[31];
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy = cnt_ff != 6'd0;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;
endmodule

// File: src/fsm_datapath.sv
module fsm_datapath
   import fsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  alu_op_type    alu_op,
   input  logic          cmp_eq,
   input  logic          cmp_swap,
   input  logic [31:0]   literal,
   output dp_status_type status,
   output logic [31:0]   reg_a,
   output logic [31:0]   reg_b,
   output logic [31:0]   reg_c,
   output logic [31:0]   alu_out,
   output logic          underflow,
   output logic          overflow,
   output logic [7:0]    depth
);
   logic [31:0] mem [StackDepth];
   logic [31:0] rdata_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0] a_ff, b_ff, c_ff, a_in, b_in, c_in, wdata;
   logic under_ff, under_in, over_ff, over_in;
   logic empty_ff, empty_in, rvalid_ff;
   logic [1:0] lsel_ff;
   logic [31:0] mul_ff, quo;
   logic mul_busy_ff, div_busy;
   logic [31:0] lt_a, lt_b;
   logic lt;
   logic empty, full;
   logic [AddrWidth-1:0] raddr;

   assign empty = count_ff == '0;
   assign full = count_ff >= CountWidth'(StackDepth);
   assign raddr = AddrWidth'(count_ff - CountWidth'(1));

   assign lt_a = cmp_swap ? b_ff : a_ff;
   assign lt_b = cmp_swap ? a_ff : b_ff;
   assign lt = $signed(lt_a) < $signed(lt_b);

   always_comb begin
      unique case (alu_op)
         ALU_A:   alu_out = a_ff;
         ALU_ADD: alu_out = a_ff + b_ff;
         ALU_SUB: alu_out = a_ff - b_ff;
         ALU_AND: alu_out = a_ff & b_ff;
         ALU_OR:  alu_out = a_ff | b_ff;
         ALU_XOR: alu_out = a_ff ^ b_ff;
         ALU_NOT: alu_out = ~a_ff;
         ALU_CMP: alu_out = (cmp_eq ? (a_ff == b_ff) : lt) ? 32'hFFFFFFFF : 32'd0;
         default: alu_out = a_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.push_sel)
         PUSH_LIT:   wdata = literal;
         PUSH_ALU:   wdata = cmd.div_start ? quo : (cmd.mul_start ? mul_ff : alu_out);
         PUSH_REG_A: wdata = a_ff;
         PUSH_REG_B: wdata = b_ff;
         PUSH_REG_C: wdata = c_ff;
         default:    wdata = literal;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      under_in = cmd.clear_flags ? 1'b0 : under_ff;
      over_in = cmd.clear_flags ? 1'b0 : over_ff;
      empty_in = empty;
      if (cmd.pop || cmd.peek) begin
         if (empty) under_in = 1'b1;
         else if (cmd.pop) count_in = count_ff - CountWidth'(1);
      end else if (cmd.push) begin
         if (full) over_in = 1'b1;
         else count_in = count_ff + CountWidth'(1);
      end
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      if (rvalid_ff) begin
         unique case (lsel_ff)
            LOAD_A:  a_in = empty_ff ? 32'd0 : rdata_ff;
            LOAD_B:  b_in = empty_ff ? 32'd0 : rdata_ff;
            default: c_in = empty_ff ? 32'd0 : rdata_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !full) mem[count_ff[AddrWidth-1:0]] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         under_ff <= 1'b0;
         over_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         mul_busy_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         under_ff <= under_in;
         over_ff <= over_in;
         rvalid_ff <= cmd.load;
         mul_busy_ff <= cmd.mul_start && !mul_busy_ff;
      end
      empty_ff <= empty_in;
      lsel_ff <= cmd.load_sel;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      mul_ff <= a_ff * b_ff;
   end

   fsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start && !div_busy && !status.div_zero && !cmd.push),
      .dividend (a_ff),
      .divisor  (b_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign status.read_valid = rvalid_ff;
   assign status.div_busy = div_busy;
   assign status.mul_busy = mul_busy_ff;
   assign status.div_zero = b_ff == 32'd0;
   assign reg_a = a_ff;
   assign reg_b = b_ff;
   assign reg_c = c_ff;
   assign underflow = under_ff;
   assign overflow = over_ff;
   assign depth = 8'(count_ff);
endmodule

// File: src/fsm_control.sv
module fsm_control
   import fsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [4:0]    req_operation,
   input  logic          port_open,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output alu_op_type    alu_op,
   output logic          cmp_eq,
   output logic          cmp_swap,
   input  logic [31:0]   reg_a,
   input  logic [31:0]   reg_b,
   input  logic [31:0]   reg_c,
   output logic          emit,
   input  logic          emit_ready,
   output logic [1:0]    emit_kind,
   output logic [7:0]    emit_status,
   output logic [6:0]    emit_d1,
   output logic [6:0]    emit_d2,
   output logic [2:0]    emit_err,
   output logic          emit_last
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_POP = 6'b000010, ST_WAIT = 6'b000100,
      ST_EXEC = 6'b001000, ST_PUSH = 6'b010000, ST_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic [1:0] npop_ff, npop_in;   // operands still to pop
   logic [1:0] step_ff, step_in;   // push step
   logic [4:0] chan_ff, chan_in;
   logic [2:0] err_ff, err_in;

   logic [1:0] nops;
   logic [31:0] ch, num, val;
   logic ch_ok, num_ok, val_ok;
   logic [2:0] midi_err;
   logic [7:0] midi_base;

   always_comb begin
      unique case (req_operation)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_AND, OP_OR, OP_XOR,
         OP_EQ, OP_LT, OP_GT, OP_OVER: nops = 2'd2;
         OP_ROT, OP_NOTEON, OP_NOTEOFF, OP_CC: nops = 2'd3;
         OP_DUP, OP_DROP, OP_NOT, OP_DOT: nops = 2'd1;
         default: nops = 2'd0;
      endcase
   end

   // Operands arrive top first: 3-pop ops fill C,B,A; 2-pop fill B,A; 1-pop fills A.
   assign ch = reg_a;
   assign num = reg_b;
   assign val = reg_c;
   assign ch_ok = ($signed(ch) >= 32'sd1) && ($signed(ch) <= 32'sd16);
   assign num_ok = num[31:7] == '0;
   assign val_ok = val[31:7] == '0;

   always_comb begin
      if (!port_open) midi_err = ERR_PORT;
      else if (!ch_ok) midi_err = ERR_CHANNEL;
      else if (op_ff != OP_CC && !num_ok) midi_err = ERR_PITCH;
      else if (op_ff == OP_NOTEON && !val_ok) midi_err = ERR_VELOCITY;
      else midi_err = ERR_NONE;
      if (op_ff == OP_NOTEON) midi_base = MSG_NOTE_ON;
      else if (op_ff == OP_NOTEOFF) midi_base = MSG_NOTE_OFF;
      else midi_base = MSG_CTRL;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      npop_in = npop_ff;
      step_in = step_ff;
      chan_in = chan_ff;
      err_in = err_ff;
      cmd = '0;
      alu_op = ALU_A;
      cmp_eq = 1'b0;
      cmp_swap = 1'b0;
      req_ready = 1'b0;
      emit = 1'b0;
      emit_kind = KIND_STATUS;
      emit_status = 8'd0;
      emit_d1 = 7'd0;
      emit_d2 = 7'd0;
      emit_last = 1'b1;
      emit_err = err_ff;

      unique case (op_ff)
         OP_ADD: alu_op = ALU_ADD;
         OP_SUB: alu_op = ALU_SUB;
         OP_AND: alu_op = ALU_AND;
         OP_OR:  alu_op = ALU_OR;
         OP_XOR: alu_op = ALU_XOR;
         OP_NOT: alu_op = ALU_NOT;
         OP_EQ: begin
            alu_op = ALU_CMP;
            cmp_eq = 1'b1;
         end
         OP_LT: alu_op = ALU_CMP;
         OP_GT: begin
            alu_op = ALU_CMP;
            cmp_swap = 1'b1;
         end
         default: alu_op = ALU_A;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_operation;
               npop_in = nops;
               step_in = 2'd0;
               chan_in = 5'd0;
               err_in = ERR_NONE;
               cmd.clear_flags = 1'b1;
               state_in = (nops != 2'd0) ? ST_POP : ST_EXEC;
            end
         end
         ST_POP: begin
            // Top of stack goes to the register of the highest operand index.
            if (op_ff == OP_DUP) cmd.peek = 1'b1;
            else if (op_ff == OP_OVER && npop_ff == 2'd1) cmd.peek = 1'b1;
            else cmd.pop = 1'b1;
            cmd.load = 1'b1;
            cmd.load_sel = (npop_ff == 2'd3) ? LOAD_C :
                           (npop_ff == 2'd2) ? LOAD_B : LOAD_A;
            npop_in = npop_ff - 2'd1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.read_valid) state_in = (npop_ff != 2'd0) ? ST_POP : ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_ROT, OP_NOTEON, OP_NOTEOFF, OP_CC, OP_PANIC, OP_MUL, OP_DIV:
                  state_in = ST_PUSH;
               OP_DROP, OP_DOT: state_in = ST_EMIT;
               default: state_in = ST_PUSH;
            endcase
            if (op_ff == OP_NOTEON || op_ff == OP_NOTEOFF || op_ff == OP_CC) begin
               err_in = midi_err;
               state_in = ST_EMIT;
            end
            if (op_ff == OP_PANIC) begin
               if (!port_open) err_in = ERR_PORT;
               state_in = ST_EMIT;
            end
            if (op_ff == OP_DIV) begin
               if (status.div_zero) begin
                  err_in = ERR_DIV_ZERO;
                  state_in = ST_EMIT;
               end else cmd.div_start = 1'b1;
            end
            if (op_ff == OP_MUL) cmd.mul_start = 1'b1;
            if (op_ff > OP_PANIC) state_in = ST_EMIT;
         end
         ST_PUSH: begin
            if (op_ff == OP_DIV && status.div_busy) begin
               state_in = ST_PUSH;
            end else if (op_ff == OP_MUL && status.mul_busy) begin
               state_in = ST_PUSH;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_EMIT;
               unique case (op_ff)
                  OP_PUSH: cmd.push_sel = PUSH_LIT;
                  OP_DUP: cmd.push_sel = PUSH_REG_A;
                  OP_DIV: begin
                     cmd.push_sel = PUSH_ALU;
                     cmd.div_start = 1'b1;
                  end
                  OP_MUL: begin
                     cmd.push_sel = PUSH_ALU;
                     cmd.mul_start = 1'b1;
                  end
                  OP_SWAP, OP_OVER: begin
                     // push b then a
                     cmd.push_sel = (step_ff == 2'd0) ? PUSH_REG_B : PUSH_REG_A;
                     if (step_ff == 2'd0) begin
                        step_in = 2'd1;
                        state_in = ST_PUSH;
                     end
                  end
                  OP_ROT: begin
                     // Rot pushes b, then c, then a.
                     unique case (step_ff)
                        2'd0: cmd.push_sel = PUSH_REG_B;
                        2'd1: cmd.push_sel = PUSH_REG_C;
                        default: cmd.push_sel = PUSH_REG_A;
                     endcase
                     if (step_ff != 2'd2) begin
                        step_in = step_ff + 2'd1;
                        state_in = ST_PUSH;
                     end
                  end
                  default: cmd.push_sel = PUSH_ALU;
               endcase
            end
         end
         ST_EMIT: begin
            emit = 1'b1;
            if (op_ff == OP_DOT) emit_kind = KIND_PRINT;
            if ((op_ff == OP_NOTEON || op_ff == OP_NOTEOFF || op_ff == OP_CC)
                && err_ff == ERR_NONE) begin
               emit_kind = KIND_MIDI;
               emit_status = midi_base | {4'd0, 4'(ch - 32'd1)};
               emit_d1 = num[6:0];
               emit_d2 = val[6:0];
            end
            if (op_ff == OP_PANIC && err_ff == ERR_NONE) begin
               emit_kind = KIND_MIDI;
               emit_status = MSG_CTRL | {4'd0, chan_ff[3:0]};
               emit_d1 = CTRL_ALL_OFF;
               emit_last = chan_ff == 5'd15;
            end
            if (emit_ready) begin
               if (!emit_last) chan_in = chan_ff + 5'd1;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      op_ff <= op_in;
      npop_ff <= npop_in;
      step_ff <= step_in;
      chan_ff <= chan_in;
      err_ff <= err_in;
   end
endmodule
